FILE: rtl/ptt_pkg.sv
// shared types and codes for the periodic and timeout timer bank
package ptt_pkg;

    localparam int OP_W      = 3;
    localparam int INDEX_W   = 3;
    localparam int VALUE_W   = 16;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_START_P = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP_P  = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY_P = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR_P = 3'd4;
    localparam logic [OP_W-1:0] OP_START_T = 3'd5;
    localparam logic [OP_W-1:0] OP_STOP_T  = 3'd6;
    localparam logic [OP_W-1:0] OP_QUERY_T = 3'd7;

    localparam logic [CFG_IDX_W-1:0] REG_PERIODS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUTS = 1'd1;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic ok;
        logic flag;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic rd_sweep;
        logic rd_op;
        logic res_load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

FILE: rtl/periodic_and_timeout_timer_bank.sv
// top level of the periodic and timeout timer bank
//
// channel   direction  handshake          payload
// in        input      in_valid/in_stall  in_item   (op, index, value)
// out       output     out_valid/out_stall out_item (ok, flag)
// cfg       input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// a tick sweeps max(NUM_PERIODS, NUM_TIMEOUTS) entries, then drains and loads a
// result; the sweep reads one entry of each bank per cycle via the ram read ports
// every other op passes through a read, a modify-write and a result load
// reset clears all entries at once through per-entry valid bits, no clearing pass
// a finished result waits in the output register while out_stall is high; a new
// item is taken meanwhile, and its result waits until the register frees
module periodic_and_timeout_timer_bank #(
    parameter int NUM_PERIODS  = 8,
    parameter int NUM_TIMEOUTS = 8,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  ptt_pkg::in_item_t             in_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output ptt_pkg::out_item_t            out_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ptt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptt_pkg::CFG_W-1:0]     cfg_data
);

    localparam int SWEEP_LEN = (NUM_PERIODS > NUM_TIMEOUTS) ? NUM_PERIODS : NUM_TIMEOUTS;
    localparam int SW        = (SWEEP_LEN > 1) ? $clog2(SWEEP_LEN) : 1;

    ptt_pkg::cmd_t cmd;
    ptt_pkg::sts_t sts;
    logic [SW-1:0] sweep_idx;
    logic          in_is_tick;

    assign in_is_tick = (in_item.op == ptt_pkg::OP_TICK);
    assign cfg_ready  = 1'b1;

    ptt_ctrl #(.SWEEP_LEN(SWEEP_LEN)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_is_tick (in_is_tick),
        .sts        (sts),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .sweep_idx  (sweep_idx)
    );

    ptt_dpath #(
        .NP (NUM_PERIODS),
        .NT (NUM_TIMEOUTS),
        .CW (COUNT_WIDTH),
        .SW (SW)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .sweep_idx (sweep_idx),
        .out_stall (out_stall),
        .sts       (sts),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    // an accepted item keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("block not busy after input transfer");

    // a result only appears at the end of a busy period
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result raised without work in flight");

    // returning to idle always leaves a result behind
    a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid)
        else $error("went idle without a result");

    // an out of range op never reports a flag
    a_flag_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.ok || !out_item.flag))
        else $error("flag set on a result with ok low");

endmodule

FILE: rtl/ptt_ram.sv
// generic simple dual port ram with registered read
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ptt_ctrl.sv
// controller state machine for the timer bank
module ptt_ctrl #(
    parameter int SWEEP_LEN = 8,
    localparam int SW = (SWEEP_LEN > 1) ? $clog2(SWEEP_LEN) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_is_tick,
    input  ptt_pkg::sts_t sts,
    output logic          in_stall,
    output ptt_pkg::cmd_t cmd,
    output logic [SW-1:0] sweep_idx
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SWEEP = 3'd1;
    localparam logic [2:0] ST_OPRD  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [SW-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = in_is_tick ? ST_SWEEP : ST_OPRD;
                end
            end
            ST_SWEEP:
            begin
                cmd.rd_sweep = 1'b1;
                if (cnt_reg == SW'(SWEEP_LEN - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_OPRD:
            begin
                cmd.rd_op  = 1'b1;
                state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign sweep_idx = cnt_reg;

endmodule

FILE: rtl/ptt_dpath.sv
// datapath of the timer bank: entry rams, valid bits, config and result registers
module ptt_dpath #(
    parameter int NP = 8,
    parameter int NT = 8,
    parameter int CW = 16,
    parameter int SW = 3
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ptt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ptt_pkg::CFG_W-1:0]       cfg_data,
    input  ptt_pkg::in_item_t               in_item,
    input  ptt_pkg::cmd_t                   cmd,
    input  logic [SW-1:0]                   sweep_idx,
    input  logic                            out_stall,
    output ptt_pkg::sts_t                   sts,
    output logic                            out_valid,
    output ptt_pkg::out_item_t              out_item
);

    localparam int PAW = (NP > 1) ? $clog2(NP) : 1;
    localparam int TAW = (NT > 1) ? $clog2(NT) : 1;
    localparam int PWW = 2 * CW + 2;

    logic [ptt_pkg::CFG_W-1:0] p_use_reg, t_use_reg;
    ptt_pkg::in_item_t         item_reg;
    logic                      ok_reg, flag_reg;
    logic                      out_valid_reg;
    ptt_pkg::out_item_t        out_item_reg;

    logic [NP-1:0]  p_valid_reg;
    logic [NT-1:0]  t_valid_reg;
    logic           p_rd_reg, t_rd_reg;
    logic [PAW-1:0] p_addr_reg;
    logic [TAW-1:0] t_addr_reg;
    logic           p_vld_rd_reg, t_vld_rd_reg;

    logic idx_in_p, idx_in_t, sweep_p_ok, sweep_t_ok, ok_c;
    logic is_pop, is_top, p_rd, t_rd;
    logic [PAW-1:0] p_raddr;
    logic [TAW-1:0] t_raddr;
    logic [PWW-1:0] p_rdata, p_word, p_wdata;
    logic [CW-1:0]  t_rdata, t_word, t_wdata;
    logic [CW-1:0]  val_c, p_cnt, p_rel, p_dec, n_cnt, n_rel;
    logic           p_act, p_done, n_act, n_done;
    logic           p_we, t_we;

    function automatic logic [ptt_pkg::INDEX_W-1:0] item_c_index(ptt_pkg::in_item_t it);
        return it.index;
    endfunction

    // range checks against the count in use, capped at the bank size
    assign idx_in_p   = (32'(item_c_index(in_item)) < 32'(p_use_reg))
                        && (32'(item_c_index(in_item)) < NP);
    assign idx_in_t   = (32'(item_c_index(in_item)) < 32'(t_use_reg))
                        && (32'(item_c_index(in_item)) < NT);
    assign sweep_p_ok = (32'(sweep_idx) < 32'(p_use_reg)) && (32'(sweep_idx) < NP);
    assign sweep_t_ok = (32'(sweep_idx) < 32'(t_use_reg)) && (32'(sweep_idx) < NT);

    always_comb
    begin
        if (in_item.op == ptt_pkg::OP_TICK)
        begin
            ok_c = 1'b1;
        end
        else if (in_item.op <= ptt_pkg::OP_CLEAR_P)
        begin
            ok_c = idx_in_p;
        end
        else
        begin
            ok_c = idx_in_t;
        end
    end

    assign is_pop = (item_reg.op >= ptt_pkg::OP_START_P) && (item_reg.op <= ptt_pkg::OP_CLEAR_P);
    assign is_top = (item_reg.op >= ptt_pkg::OP_START_T);

    assign p_rd    = (cmd.rd_sweep && sweep_p_ok) || (cmd.rd_op && is_pop && ok_reg);
    assign t_rd    = (cmd.rd_sweep && sweep_t_ok) || (cmd.rd_op && is_top && ok_reg);
    assign p_raddr = cmd.rd_sweep ? PAW'(sweep_idx) : PAW'(item_reg.index);
    assign t_raddr = cmd.rd_sweep ? TAW'(sweep_idx) : TAW'(item_reg.index);

    // never-written entries read as zero
    assign p_word = p_vld_rd_reg ? p_rdata : '0;
    assign t_word = t_vld_rd_reg ? t_rdata : '0;

    assign val_c  = CW'(item_reg.value);
    assign p_cnt  = p_word[CW-1:0];
    assign p_rel  = p_word[2*CW-1:CW];
    assign p_act  = p_word[2*CW];
    assign p_done = p_word[2*CW+1];
    assign p_dec  = p_cnt - 1'b1;

    always_comb
    begin
        n_cnt  = p_cnt;
        n_rel  = p_rel;
        n_act  = p_act;
        n_done = p_done;
        unique case (item_reg.op)
            ptt_pkg::OP_TICK:
            begin
                if (p_act)
                begin
                    // reaching zero reloads and flags done
                    if (p_dec == '0)
                    begin
                        n_done = 1'b1;
                        n_cnt  = p_rel;
                    end
                    else
                    begin
                        n_cnt = p_dec;
                    end
                end
            end
            ptt_pkg::OP_START_P:
            begin
                n_cnt  = val_c;
                n_rel  = val_c;
                n_act  = 1'b1;
                n_done = 1'b0;
            end
            ptt_pkg::OP_STOP_P:
            begin
                n_act = 1'b0;
            end
            ptt_pkg::OP_CLEAR_P:
            begin
                n_done = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    assign p_wdata = {n_done, n_act, n_rel, n_cnt};
    assign p_we    = p_rd_reg && (item_reg.op != ptt_pkg::OP_QUERY_P);

    always_comb
    begin
        t_wdata = t_word;
        unique case (item_reg.op)
            ptt_pkg::OP_TICK:
            begin
                if (t_word != '0)
                begin
                    t_wdata = t_word - 1'b1;
                end
            end
            ptt_pkg::OP_START_T:
            begin
                t_wdata = val_c;
            end
            ptt_pkg::OP_STOP_T:
            begin
                t_wdata = '0;
            end
            default:
            begin
            end
        endcase
    end

    assign t_we = t_rd_reg && (item_reg.op != ptt_pkg::OP_QUERY_T);

    ptt_ram #(.WIDTH(PWW), .DEPTH(NP)) u_p_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_addr_reg),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    ptt_ram #(.WIDTH(CW), .DEPTH(NT)) u_t_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_addr_reg),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_use_reg     <= ptt_pkg::CFG_RESET;
            t_use_reg     <= ptt_pkg::CFG_RESET;
            p_valid_reg   <= '0;
            t_valid_reg   <= '0;
            p_rd_reg      <= 1'b0;
            t_rd_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ptt_pkg::REG_PERIODS:  p_use_reg <= cfg_data;
                    ptt_pkg::REG_TIMEOUTS: t_use_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            p_rd_reg <= p_rd;
            t_rd_reg <= t_rd;
            if (p_we)
            begin
                p_valid_reg[p_addr_reg] <= 1'b1;
            end
            if (t_we)
            begin
                t_valid_reg[t_addr_reg] <= 1'b1;
            end
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_addr_reg   <= p_raddr;
        t_addr_reg   <= t_raddr;
        p_vld_rd_reg <= p_valid_reg[p_raddr];
        t_vld_rd_reg <= t_valid_reg[t_raddr];
        if (cmd.load)
        begin
            item_reg <= in_item;
            ok_reg   <= ok_c;
            flag_reg <= 1'b0;
        end
        else if (p_rd_reg && (item_reg.op == ptt_pkg::OP_QUERY_P))
        begin
            flag_reg <= p_done;
        end
        else if (t_rd_reg && (item_reg.op == ptt_pkg::OP_QUERY_T))
        begin
            flag_reg <= (t_word == '0);
        end
        if (cmd.res_load)
        begin
            out_item_reg.ok   <= ok_reg;
            out_item_reg.flag <= flag_reg;
        end
    end

    assign sts.out_free = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign out_item     = out_item_reg;

endmodule
